// ----- rtl/core/pbe_pkg.sv -----
// ----------------------------------------------------------------------------
// PackBits line encoder package
// Shared types and fixed constants of the line encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pbe_pkg;

  // Command codes of the input channel
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  // PackBits limits
  localparam int RUN_MAX  = 128;
  localparam int LIT_MAX  = 127;
  localparam int JOIN_MAX = 125;

  // Encoder sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT,
    S_STRIP_RD,
    S_STRIP_CHK,
    S_COPY_RD,
    S_COPY_WR,
    S_B_RD,
    S_B_GET,
    S_RUN_RD,
    S_RUN_CHK,
    S_JOIN_RD,
    S_JOIN_CHK,
    S_DECIDE,
    S_LIT,
    S_FLUSH,
    S_RUN_HDR,
    S_RUN_BYTE
  } enc_state_t;

  // Control from the top level to the encoder
  typedef struct packed {
    logic start;
    logic compress;
  } enc_ctl_t;

  // Status from the encoder to the top level
  typedef struct packed {
    logic busy;
    logic done;
  } enc_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/packbits_line_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// PackBits line encoder
// Loads a raster line, strips trailing zeros, PackBits-encodes or copies it,
// and returns the output one byte per fetch.
// ----------------------------------------------------------------------------
// Load: one byte per cycle while not stalled; the end-of-line byte stalls input
// for the encode pass. Fetch: the beat passes the pending and result registers,
// and the next item is taken the cycle after delivery.
// Reset (rst_n, synchronous): clears counters, flags and state; memories keep
// their contents, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module packbits_line_encoder_unit #(
  parameter int LINE_BYTES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_line,
  output logic             out_rsp_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_valid,
  output logic             out_last,
  output logic [10:0]      out_encoded_length,
  output logic             out_line_overflow
);

  import pbe_pkg::*;

  localparam int LA  = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int LCW = $clog2(LINE_BYTES + 1);
  localparam int EA  = $clog2(LINE_BYTES + LINE_BYTES / 128 + 2);
  localparam int ECW = $clog2(LINE_BYTES + LINE_BYTES / 128 + 3);

  logic           cmp_r;
  logic           ready_r;
  logic           ready_nxt;
  logic           accept;
  logic           load;
  logic           fetch;
  logic           pending;
  enc_ctl_t       ctl;
  enc_sts_t       sts;
  logic [LCW-1:0] load_count;
  logic           overflow;
  logic [LA-1:0]  line_addr;
  logic [7:0]     line_data;
  logic           wr_en;
  logic [EA-1:0]  wr_addr;
  logic [7:0]     wr_data;
  logic [ECW-1:0] enc_count;

  // Take configuration at any time; it is to be written only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      cmp_r <= cfg_data;
    end
  end

  // Hold input while encoding or while a fetch beat is in flight
  assign in_stall = sts.busy || pending || out_rsp_valid;
  assign accept   = in_valid && !in_stall;
  assign load     = accept && (in_command == CMD_LOAD);
  assign fetch    = accept && (in_command == CMD_FETCH);

  assign ctl.start    = load && in_end_of_line;
  assign ctl.compress = cmp_r;

  always_comb begin
    ready_nxt = ready_r;
    if (load) begin
      ready_nxt = 1'b0;
    end
    if (sts.done) begin
      ready_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
    end else begin
      ready_r <= ready_nxt;
    end
  end

  pbe_line_buf #(
    .LINE_BYTES (LINE_BYTES)
  ) u_line_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_en    (load),
    .load_clear (ready_r),
    .load_data  (in_data_byte),
    .rd_addr    (line_addr),
    .rd_data    (line_data),
    .load_count (load_count),
    .overflow   (overflow)
  );

  pbe_encoder #(
    .LINE_BYTES (LINE_BYTES)
  ) u_encoder (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .line_count (load_count),
    .line_addr  (line_addr),
    .line_data  (line_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .enc_count  (enc_count)
  );

  pbe_out_buf #(
    .LINE_BYTES (LINE_BYTES)
  ) u_out_buf (
    .clk                (clk),
    .rst_n              (rst_n),
    .wr_en              (wr_en),
    .wr_addr            (wr_addr),
    .wr_data            (wr_data),
    .enc_count          (enc_count),
    .ptr_clear          (ctl.start),
    .fetch              (fetch),
    .line_ready         (ready_r),
    .overflow           (overflow),
    .out_stall          (out_stall),
    .pending            (pending),
    .out_rsp_valid      (out_rsp_valid),
    .out_byte           (out_byte),
    .out_valid          (out_valid),
    .out_last           (out_last),
    .out_encoded_length (out_encoded_length),
    .out_line_overflow  (out_line_overflow)
  );

endmodule

`default_nettype wire

// ----- rtl/core/pbe_line_buf.sv -----
// ----------------------------------------------------------------------------
// PackBits line buffer
// Raster line memory with load counter, overflow flag and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pbe_line_buf #(
  parameter int LINE_BYTES = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              load_en,
  input  wire logic                              load_clear,
  input  wire logic [7:0]                        load_data,
  input  wire logic [((LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1)-1:0] rd_addr,
  output logic      [7:0]                        rd_data,
  output logic      [$clog2(LINE_BYTES+1)-1:0]   load_count,
  output logic                                   overflow
);

  localparam int LA  = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int LCW = $clog2(LINE_BYTES + 1);

  logic [7:0]     mem [LINE_BYTES];
  logic [LCW-1:0] cnt_r;
  logic [LCW-1:0] cnt_nxt;
  logic           ovf_r;
  logic           ovf_nxt;
  logic [LCW-1:0] base;
  logic           room;

  // Restart the count when a new line follows a finished one
  assign base = load_clear ? '0 : cnt_r;
  assign room = (base < LCW'(LINE_BYTES));

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (load_en) begin
      if (load_clear) begin
        ovf_nxt = 1'b0;
      end
      if (room) begin
        cnt_nxt = base + LCW'(1);
      end else begin
        cnt_nxt = base;
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  // Store the byte; drop it past capacity
  always_ff @(posedge clk) begin
    if (load_en && room) begin
      mem[base[LA-1:0]] <= load_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign load_count = cnt_r;
  assign overflow   = ovf_r;

endmodule

`default_nettype wire

// ----- rtl/core/pbe_encoder.sv -----
// ----------------------------------------------------------------------------
// PackBits encoder sequencer
// Strips trailing zeros and encodes or copies the stored line into the output memory.
// ----------------------------------------------------------------------------
`default_nettype none

module pbe_encoder #(
  parameter int LINE_BYTES = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire pbe_pkg::enc_ctl_t         ctl,
  output pbe_pkg::enc_sts_t              sts,
  input  wire logic [$clog2(LINE_BYTES+1)-1:0] line_count,
  output logic [((LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1)-1:0] line_addr,
  input  wire logic [7:0]                line_data,
  output logic                           wr_en,
  output logic [$clog2(LINE_BYTES + LINE_BYTES / 128 + 2)-1:0] wr_addr,
  output logic [7:0]                     wr_data,
  output logic [$clog2(LINE_BYTES + LINE_BYTES / 128 + 3)-1:0] enc_count
);

  import pbe_pkg::*;

  localparam int LA  = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int LCW = $clog2(LINE_BYTES + 1);
  localparam int EA  = $clog2(LINE_BYTES + LINE_BYTES / 128 + 2);
  localparam int ECW = $clog2(LINE_BYTES + LINE_BYTES / 128 + 3);

  enc_state_t     state_r, state_nxt;
  logic [LCW-1:0] n_r, n_nxt;
  logic [LCW-1:0] p_r, p_nxt;
  logic [7:0]     c_r, c_nxt;
  logic [6:0]     lit_r, lit_nxt;
  logic [7:0]     b_r, b_nxt;
  logic [7:0]     nb_r, nb_nxt;
  logic           ne_r, ne_nxt;
  logic           cmp_r, cmp_nxt;
  logic [EA-1:0]  hdr_r, hdr_nxt;
  logic [ECW-1:0] ecnt_r, ecnt_nxt;
  logic           done;
  logic           join_ok;
  logic [LCW-1:0] rem;

  assign rem = n_r - p_r;

  // A two-byte run folds into pending literals when no run follows it
  assign join_ok = (c_r == 8'd2) && (lit_r != 7'd0) && (int'(lit_r) <= JOIN_MAX) &&
                   ((rem <= LCW'(2)) || (int'(rem) <= 2) || ne_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    p_r    <= p_nxt;
    c_r    <= c_nxt;
    lit_r  <= lit_nxt;
    b_r    <= b_nxt;
    nb_r   <= nb_nxt;
    ne_r   <= ne_nxt;
    cmp_r  <= cmp_nxt;
    hdr_r  <= hdr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecnt_r <= '0;
    end else begin
      ecnt_r <= ecnt_nxt;
    end
  end

  // Sequence the strip, copy and encode passes
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    p_nxt     = p_r;
    c_nxt     = c_r;
    lit_nxt   = lit_r;
    b_nxt     = b_r;
    nb_nxt    = nb_r;
    ne_nxt    = ne_r;
    cmp_nxt   = cmp_r;
    hdr_nxt   = hdr_r;
    ecnt_nxt  = ecnt_r;
    line_addr = LA'(p_r);
    wr_en     = 1'b0;
    wr_addr   = EA'(ecnt_r);
    wr_data   = b_r;
    done      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          cmp_nxt   = ctl.compress;
          ecnt_nxt  = '0;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        n_nxt     = line_count;
        p_nxt     = '0;
        lit_nxt   = '0;
        state_nxt = S_STRIP_RD;
      end
      S_STRIP_RD: begin
        line_addr = LA'(n_r - LCW'(1));
        if (n_r == '0) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_STRIP_CHK;
        end
      end
      S_STRIP_CHK: begin
        if (line_data == 8'd0) begin
          n_nxt     = n_r - LCW'(1);
          state_nxt = S_STRIP_RD;
        end else begin
          state_nxt = cmp_r ? S_B_RD : S_COPY_RD;
        end
      end
      S_COPY_RD: begin
        if (p_r == n_r) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_COPY_WR;
        end
      end
      S_COPY_WR: begin
        wr_en     = 1'b1;
        wr_data   = line_data;
        ecnt_nxt  = ecnt_r + ECW'(1);
        p_nxt     = p_r + LCW'(1);
        state_nxt = S_COPY_RD;
      end
      S_B_RD: begin
        if (p_r == n_r) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_B_GET;
        end
      end
      S_B_GET: begin
        b_nxt     = line_data;
        p_nxt     = p_r + LCW'(1);
        c_nxt     = 8'd1;
        ne_nxt    = 1'b1;
        state_nxt = S_RUN_RD;
      end
      S_RUN_RD: begin
        if ((p_r < n_r) && (int'(c_r) < RUN_MAX)) begin
          state_nxt = S_RUN_CHK;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_RUN_CHK: begin
        if (line_data == b_r) begin
          c_nxt     = c_r + 8'd1;
          p_nxt     = p_r + LCW'(1);
          state_nxt = S_RUN_RD;
        end else begin
          nb_nxt = line_data;
          if ((c_r == 8'd2) && (lit_r != 7'd0) && (int'(lit_r) <= JOIN_MAX) &&
              (int'(rem) > 2)) begin
            state_nxt = S_JOIN_RD;
          end else begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_JOIN_RD: begin
        line_addr = LA'(p_r + LCW'(1));
        state_nxt = S_JOIN_CHK;
      end
      S_JOIN_CHK: begin
        ne_nxt    = (line_data != nb_r);
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (join_ok || (c_r == 8'd1)) begin
          if (join_ok) begin
            p_nxt = p_r - LCW'(1);
          end
          state_nxt = S_LIT;
        end else if (lit_r != 7'd0) begin
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_RUN_HDR;
        end
      end
      S_LIT: begin
        // Reserve the header slot ahead of the first literal
        wr_en = 1'b1;
        c_nxt = 8'd0;
        if (lit_r == 7'd0) begin
          hdr_nxt  = EA'(ecnt_r);
          wr_addr  = EA'(ecnt_r + ECW'(1));
          ecnt_nxt = ecnt_r + ECW'(2);
        end else begin
          ecnt_nxt = ecnt_r + ECW'(1);
        end
        lit_nxt = lit_r + 7'd1;
        if ((int'(lit_r) + 1 == LIT_MAX) || (p_r == n_r)) begin
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_B_RD;
        end
      end
      S_FLUSH: begin
        wr_en     = 1'b1;
        wr_addr   = hdr_r;
        wr_data   = 8'(lit_r - 7'd1);
        lit_nxt   = '0;
        state_nxt = (c_r > 8'd1) ? S_RUN_HDR : S_B_RD;
      end
      S_RUN_HDR: begin
        // Header first, then the run byte
        wr_en     = 1'b1;
        wr_data   = 8'd1 - c_r;
        ecnt_nxt  = ecnt_r + ECW'(1);
        c_nxt     = 8'd1;
        state_nxt = S_RUN_BYTE;
      end
      S_RUN_BYTE: begin
        wr_en     = 1'b1;
        wr_data   = b_r;
        ecnt_nxt  = ecnt_r + ECW'(1);
        state_nxt = S_B_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign sts.busy  = (state_r != S_IDLE);
  assign sts.done  = done;
  assign enc_count = ecnt_r;

endmodule

`default_nettype wire

// ----- rtl/core/pbe_out_buf.sv -----
// ----------------------------------------------------------------------------
// PackBits output buffer
// Encoded byte memory with read pointer and registered result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module pbe_out_buf #(
  parameter int LINE_BYTES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr_en,
  input  wire logic [$clog2(LINE_BYTES + LINE_BYTES / 128 + 2)-1:0] wr_addr,
  input  wire logic [7:0]  wr_data,
  input  wire logic [$clog2(LINE_BYTES + LINE_BYTES / 128 + 3)-1:0] enc_count,
  input  wire logic        ptr_clear,
  input  wire logic        fetch,
  input  wire logic        line_ready,
  input  wire logic        overflow,
  input  wire logic        out_stall,
  output logic             pending,
  output logic             out_rsp_valid,
  output logic [7:0]       out_byte,
  output logic             out_valid,
  output logic             out_last,
  output logic [10:0]      out_encoded_length,
  output logic             out_line_overflow
);

  localparam int ENC_CAP = LINE_BYTES + LINE_BYTES / 128 + 2;
  localparam int EA      = $clog2(ENC_CAP);
  localparam int ECW     = $clog2(ENC_CAP + 1);

  logic [7:0]     mem [ENC_CAP];
  logic [7:0]     rd_data;
  logic [ECW-1:0] ptr_r;
  logic           hit;
  logic           pend_r;
  logic           hit_r;
  logic           last_r;
  logic [10:0]    len_r;
  logic           ovf_r;
  logic           ov_r;

  assign hit = line_ready && (ptr_r < enc_count);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[ptr_r[EA-1:0]];
  end

  // Advance the pointer and set the pending and result-valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (ptr_clear) begin
        ptr_r <= '0;
      end else if (fetch && hit) begin
        ptr_r <= ptr_r + ECW'(1);
      end
      pend_r <= fetch;
      if (pend_r) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fetch) begin
      hit_r  <= hit;
      last_r <= hit && (ptr_r + ECW'(1) == enc_count);
      len_r  <= line_ready ? 11'(enc_count) : 11'd0;
      ovf_r  <= overflow;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (pend_r) begin
      out_byte           <= hit_r ? rd_data : 8'd0;
      out_valid          <= hit_r;
      out_last           <= last_r;
      out_encoded_length <= len_r;
      out_line_overflow  <= ovf_r;
    end
  end

  assign pending       = pend_r;
  assign out_rsp_valid = ov_r;

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// Line encoder testbench
// Drives load and fetch beats into the encoder, predicts every fetch result
// from a local PackBits model and compares each result beat field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pbe_pkg::*;

  localparam int LINE_CAP = 1024;
  localparam int ENC_LIMIT = LINE_CAP + LINE_CAP / 128 + 2;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [7:0]  byte_val;
    logic        valid;
    logic        last;
    logic [10:0] enc_len;
    logic        ovf;
  } fetch_rsp_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready, cfg_data;
  logic in_valid, in_stall, in_command, in_end_of_line;
  logic [7:0] in_data_byte;
  logic out_rsp_valid, out_stall;
  logic [7:0] out_byte;
  logic out_valid, out_last, out_line_overflow;
  logic [10:0] out_encoded_length;

  packbits_line_encoder_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_data_byte(in_data_byte), .in_end_of_line(in_end_of_line),
    .out_rsp_valid(out_rsp_valid), .out_stall(out_stall), .out_byte(out_byte),
    .out_valid(out_valid), .out_last(out_last),
    .out_encoded_length(out_encoded_length), .out_line_overflow(out_line_overflow)
  );

  // Predictor state
  logic        pk_compress;
  logic [7:0]  pk_line [LINE_CAP];
  int          pk_load_cnt;
  logic [7:0]  pk_enc [ENC_LIMIT];
  int          pk_enc_cnt;
  int          pk_rd_ptr;
  logic        pk_ready;
  logic        pk_ovf;

  fetch_rsp_t  rsp_queue [$];
  int          errors = 0;
  int          loads_sent = 0, fetches_sent = 0, rsp_seen = 0;
  int          send_idle_pct = 14, recv_idle_pct = 54;
  int          idle_cycles = 0;
  bit          timed_out = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic enc_put(input int v);
    if (pk_enc_cnt < ENC_LIMIT) begin
      pk_enc[pk_enc_cnt] = v[7:0];
      pk_enc_cnt++;
    end
  endtask

  // Strip trailing zeros, then copy or PackBits-encode the stored line
  task automatic encode_line();
    int n, p, lit, c, rem, start;
    logic [7:0] b;
    n = pk_load_cnt;
    p = 0;
    lit = 0;
    while (n > 0 && pk_line[n-1] == 8'h00) n--;
    pk_enc_cnt = 0;
    pk_rd_ptr = 0;
    if (!pk_compress) begin
      for (int k = 0; k < n; k++) enc_put(pk_line[k]);
      return;
    end
    while (p < n) begin
      b = pk_line[p];
      c = 1;
      p++;
      rem = n - p;
      while (rem > 0 && pk_line[p] == b && c < RUN_MAX) begin
        c++; p++; rem--;
      end
      // short run joins pending literals unless a run follows
      if (c == 2 && lit > 0 && lit <= JOIN_MAX &&
          (rem <= 2 || pk_line[p] != pk_line[p+1])) begin
        c = 1; p--; rem++;
      end
      if (c == 1) begin
        lit++; c = 0;
      end
      if (lit > 0 && (c > 1 || lit == LIT_MAX || rem == 0)) begin
        start = p - c - lit;
        enc_put(lit - 1);
        for (int k = 0; k < lit; k++) enc_put(pk_line[start + k]);
        lit = 0;
      end
      if (c > 1) begin
        enc_put(1 - c);
        enc_put(b);
      end
    end
  endtask

  // Advance the predictor by one accepted input beat
  task automatic predict_beat(input logic cmd, input logic [7:0] d, input logic eol);
    fetch_rsp_t r;
    if (cmd == CMD_LOAD) begin
      if (pk_ready) begin
        pk_load_cnt = 0; pk_enc_cnt = 0; pk_rd_ptr = 0; pk_ovf = 0; pk_ready = 0;
      end
      if (pk_load_cnt < LINE_CAP) begin
        pk_line[pk_load_cnt] = d;
        pk_load_cnt++;
      end else pk_ovf = 1;
      if (eol) begin
        encode_line();
        pk_ready = 1;
      end
      return;
    end
    r = '0;
    if (pk_ready && pk_rd_ptr < pk_enc_cnt) begin
      r.byte_val = pk_enc[pk_rd_ptr];
      r.valid = 1;
      r.last = (pk_rd_ptr + 1 == pk_enc_cnt);
      pk_rd_ptr++;
    end
    r.enc_len = pk_ready ? pk_enc_cnt[10:0] : 11'd0;
    r.ovf = pk_ovf;
    rsp_queue.push_back(r);
  endtask

  // Drive one input beat and hold it until accepted
  task automatic send_beat(input logic cmd, input logic [7:0] d, input logic eol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_command <= cmd;
    in_data_byte <= d;
    in_end_of_line <= eol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(cmd, d, eol);
    if (cmd == CMD_LOAD) loads_sent++; else fetches_sent++;
  endtask

  // Send a directed fetch whose result is also checked against a typed value
  task automatic fetch_known(input fetch_rsp_t want);
    send_beat(CMD_FETCH, 8'h00, 0);
    if (rsp_queue[$] !== want) begin
      $display("%0t directed fetch: expected %h actual %h", $time, want, rsp_queue[$]);
      errors++;
    end
  endtask

  task automatic load_line(input logic [7:0] bytes [$]);
    foreach (bytes[i]) send_beat(CMD_LOAD, bytes[i], i == bytes.size() - 1);
  endtask

  task automatic drain_line(input int extra);
    int n;
    n = pk_enc_cnt - pk_rd_ptr + extra;
    for (int i = 0; i < n; i++) send_beat(CMD_FETCH, 8'($urandom), 0);
  endtask

  // Drop valid and wait for every result and the encode pass to finish
  task automatic wait_idle();
    in_valid <= 0;
    while (rsp_queue.size() != 0 || in_stall) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(input logic v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    pk_compress = v;
  endtask

  // Random line: mostly runs and literal mixes, sometimes long or zero-tailed
  task automatic random_line(input bit allow_long);
    logic [7:0] q [$];
    logic [7:0] v;
    int len, seg;
    len = allow_long ? LINE_CAP + $urandom_range(1, 20) : $urandom_range(1, 40);
    if (!allow_long && $urandom_range(9) == 0) len = $urandom_range(120, 300);
    while (q.size() < len) begin
      v = 8'($urandom);
      seg = $urandom_range(3) == 0 ? $urandom_range(1, 140) : $urandom_range(1, 3);
      if ($urandom_range(7) == 0) v = 8'h00;
      for (int i = 0; i < seg && q.size() < len; i++)
        q.push_back(($urandom_range(3) == 0 && seg < 4) ? 8'($urandom) : v);
    end
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 5)) q.push_back(8'h00);
    load_line(q);
  endtask

  // Compare every result beat with the oldest prediction
  always @(posedge clk) begin
    fetch_rsp_t want, got;
    if (rst_n && out_rsp_valid && !out_stall) begin
      got = '{out_byte, out_valid, out_last, out_encoded_length, out_line_overflow};
      rsp_seen++;
      if (rsp_queue.size() == 0) begin
        $display("%0t unexpected result beat: actual %h", $time, got);
        errors++;
      end else begin
        want = rsp_queue.pop_front();
        if (got !== want) begin
          $display("%0t result mismatch: expected byte %h valid %b last %b len %0d ovf %b",
                   $time, want.byte_val, want.valid, want.last, want.enc_len, want.ovf);
          $display("%0t                  actual   byte %h valid %b last %b len %0d ovf %b",
                   $time, got.byte_val, got.valid, got.last, got.enc_len, got.ovf);
          errors++;
        end
      end
    end
  end

  // Random receiver stall
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // Watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_rsp_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("Test completed with failures");
      $finish;
    end
  end

  typedef struct {
    logic cmd;
    logic [7:0] d;
    logic eol;
    bit typed;
    fetch_rsp_t want;
  } dir_row_t;

  initial begin
    dir_row_t rows [$];
    int phase_items;
    rst_n = 0;
    cfg_valid = 0; cfg_data = 0;
    in_valid = 0; in_command = 0; in_data_byte = 0; in_end_of_line = 0;
    out_stall = 0;
    pk_compress = 1; pk_load_cnt = 0; pk_enc_cnt = 0; pk_rd_ptr = 0;
    pk_ready = 0; pk_ovf = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed table: fetch before a line, literal/run lines, empty line
    rows = '{
      '{CMD_FETCH, 8'h00, 0, 1, '{8'h00, 0, 0, 11'd0, 0}},
      '{CMD_LOAD,  8'hFF, 0, 0, '0},
      '{CMD_LOAD,  8'hFF, 0, 0, '0},
      '{CMD_LOAD,  8'hFF, 1, 0, '0},
      '{CMD_FETCH, 8'h00, 0, 1, '{8'hFE, 1, 0, 11'd2, 0}},
      '{CMD_FETCH, 8'h00, 0, 1, '{8'hFF, 1, 1, 11'd2, 0}},
      '{CMD_FETCH, 8'h00, 0, 1, '{8'h00, 0, 0, 11'd2, 0}},
      '{CMD_LOAD,  8'h01, 0, 0, '0},
      '{CMD_LOAD,  8'h02, 0, 0, '0},
      '{CMD_LOAD,  8'h02, 0, 0, '0},
      '{CMD_LOAD,  8'h03, 0, 0, '0},
      '{CMD_LOAD,  8'h00, 1, 0, '0},
      '{CMD_FETCH, 8'h00, 0, 0, '0},
      '{CMD_FETCH, 8'h00, 0, 0, '0},
      '{CMD_FETCH, 8'h00, 0, 0, '0},
      '{CMD_FETCH, 8'h00, 0, 0, '0},
      '{CMD_FETCH, 8'hFF, 0, 0, '0},
      '{CMD_FETCH, 8'h00, 0, 0, '0},
      '{CMD_LOAD,  8'h00, 0, 0, '0},
      '{CMD_LOAD,  8'h00, 1, 0, '0},
      '{CMD_FETCH, 8'h00, 0, 1, '{8'h00, 0, 0, 11'd0, 0}}
    };
    foreach (rows[i]) begin
      if (rows[i].typed) fetch_known(rows[i].want);
      else send_beat(rows[i].cmd, rows[i].d, rows[i].eol);
    end
    // Let the sender hold off until all results are back
    wait_idle();

    // Overflow line, then a few fetches to check the flag and the length
    random_line(1);
    repeat (4) send_beat(CMD_FETCH, 8'($urandom), 0);
    wait_idle();

    // Random phases across idle profiles and register settings
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 54; recv_idle_pct = 14;
      end else if (ph == 2) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      for (int s = 0; s < 2; s++) begin
        wait_idle();
        write_cfg(1'($urandom_range(1)));
        phase_items = loads_sent + fetches_sent;
        while (loads_sent + fetches_sent - phase_items < 80) begin
          random_line(0);
          // Sometimes switch the register mid-line is not allowed; mix partial reads
          if ($urandom_range(5) == 0) drain_line(0);
          else if ($urandom_range(4) == 0)
            repeat ($urandom_range(0, 3)) send_beat(CMD_FETCH, 8'($urandom), 0);
          else drain_line($urandom_range(0, 2));
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (rsp_queue.size() != 0) begin
      $display("%0t %0d predicted results never arrived", $time, rsp_queue.size());
      errors++;
    end
    $display("Covered %0d load beats and %0d fetch beats, %0d results checked,",
             loads_sent, fetches_sent, rsp_seen);
    $display("both encoding modes, overflowing and empty lines, three idle profiles.");
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

// ----- packbits_line_encoder_unit.f -----
rtl/core/pbe_pkg.sv
rtl/core/pbe_line_buf.sv
rtl/core/pbe_encoder.sv
rtl/core/pbe_out_buf.sv
rtl/core/packbits_line_encoder_unit.sv
dv/tb.sv
